### design/assert_macros.svh
// Assertion macros used by the markup tag stripper unit.
// No dependencies; the checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define CHK_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("forbidden condition seen");
`else
`define CHK_ASSERT(label, clk, rst_n, prop)
`define CHK_NEVER(label, clk, rst_n, prop)
`endif
`endif

### design/mkts_pkg.sv
// Types, character constants and match helpers for the markup tag stripper.
// No dependencies.
package mkts_pkg;

	typedef enum logic [2:0] {
		MODE_TEXT   = 3'd0,
		MODE_OPEN   = 3'd1,
		MODE_TAG    = 3'd2,
		MODE_CMT    = 3'd3,
		MODE_STYLE  = 3'd4,
		MODE_CLOSE  = 3'd5,
		MODE_SCRIPT = 3'd6
	} mode_t;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int unsigned CMT_LEN        = 3;
	localparam int unsigned STYLE_LEN      = 5;
	localparam int unsigned SCRIPT_LEN     = 6;
	localparam int unsigned END_STYLE_LEN  = 7;
	localparam int unsigned END_SCRIPT_LEN = 8;

	// Bit positions in the candidate mask.
	localparam int unsigned CAND_CMT    = 0;
	localparam int unsigned CAND_STYLE  = 1;
	localparam int unsigned CAND_SCRIPT = 2;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_open_skip(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
	endfunction

	// "!--"
	function automatic logic [7:0] cmt_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h21;
			3'd1: r = CH_DASH;
			3'd2: r = CH_DASH;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// "style"
	function automatic logic [7:0] style_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h73;
			3'd1: r = 8'h74;
			3'd2: r = 8'h79;
			3'd3: r = 8'h6C;
			3'd4: r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// "script"
	function automatic logic [7:0] script_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h73;
			3'd1: r = 8'h63;
			3'd2: r = 8'h72;
			3'd3: r = 8'h69;
			3'd4: r = 8'h70;
			3'd5: r = 8'h74;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// "</style"
	function automatic logic [7:0] end_style_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = CH_LT;
			3'd1: r = 8'h2F;
			3'd2: r = 8'h73;
			3'd3: r = 8'h74;
			3'd4: r = 8'h79;
			3'd5: r = 8'h6C;
			3'd6: r = 8'h65;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// "</script"
	function automatic logic [7:0] end_script_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = CH_LT;
			3'd1: r = 8'h2F;
			3'd2: r = 8'h73;
			3'd3: r = 8'h63;
			3'd4: r = 8'h72;
			3'd5: r = 8'h69;
			3'd6: r = 8'h70;
			3'd7: r = 8'h74;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

### design/markup_tag_stripper_unit.sv
// Markup tag stripper: one input byte in, one result out per request.
// An accepted request waits in the input stage, then its result is registered.
// Throughput: one request per cycle unless rslt_ready stalls the result stage.
// Reset: arst_n clears both stages and returns the scanner to plain text.
// Depends on mkts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module markup_tag_stripper_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       rslt_valid,
	input  logic       rslt_ready,
	output logic [7:0] out_char,
	output logic       out_valid,
	output logic       out_last
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Scanner state.
	mkts_pkg::mode_t mode_q;
	logic [2:0]      pos_q;
	logic [2:0]      cand_q;
	logic [1:0]      dash_q;
	logic            prev_space_q;

	// Result stage.
	logic       rslt_valid_q;
	logic [7:0] out_char_q;
	logic       out_valid_q;
	logic       out_last_q;

	mkts_pkg::mode_t n_mode;
	logic [2:0]      n_pos;
	logic [2:0]      n_cand;
	logic [1:0]      n_dash;
	logic            n_prev;
	logic [7:0]      o_char;
	logic            o_valid;

	logic [7:0] lc;
	logic [3:0] p_inc;
	logic       out_free;
	logic       adv_s1;

	assign out_free = !rslt_valid_q || rslt_ready;
	assign adv_s1   = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign lc       = mkts_pkg::to_lower(char_s1);
	assign p_inc    = {1'b0, pos_q} + 4'd1;

	// Next-state logic.
	always_comb begin
		n_mode = mode_q;
		n_pos  = pos_q;
		n_cand = cand_q;
		n_dash = dash_q;
		n_prev = prev_space_q;
		case (mode_q)
			mkts_pkg::MODE_OPEN: begin
				if (!(pos_q == 3'd0 && mkts_pkg::is_open_skip(char_s1))) begin
					if (!(pos_q < 3'(mkts_pkg::CMT_LEN) &&
					      char_s1 == mkts_pkg::cmt_char(pos_q))) begin
						n_cand[mkts_pkg::CAND_CMT] = 1'b0;
					end
					if (!(pos_q < 3'(mkts_pkg::STYLE_LEN) &&
					      lc == mkts_pkg::style_char(pos_q))) begin
						n_cand[mkts_pkg::CAND_STYLE] = 1'b0;
					end
					if (!(pos_q < 3'(mkts_pkg::SCRIPT_LEN) &&
					      lc == mkts_pkg::script_char(pos_q))) begin
						n_cand[mkts_pkg::CAND_SCRIPT] = 1'b0;
					end
					n_pos = p_inc[2:0];
					if (n_cand[mkts_pkg::CAND_CMT] && p_inc == 4'(mkts_pkg::CMT_LEN)) begin
						n_mode = mkts_pkg::MODE_CMT;
						n_dash = 2'd0;
						n_pos  = 3'd0;
					end else if (n_cand[mkts_pkg::CAND_STYLE] &&
					             p_inc == 4'(mkts_pkg::STYLE_LEN)) begin
						n_mode = mkts_pkg::MODE_STYLE;
						n_pos  = 3'd0;
					end else if (n_cand[mkts_pkg::CAND_SCRIPT] &&
					             p_inc == 4'(mkts_pkg::SCRIPT_LEN)) begin
						n_mode = mkts_pkg::MODE_SCRIPT;
						n_pos  = 3'd0;
					end else if (n_cand == 3'd0) begin
						n_mode = (char_s1 == mkts_pkg::CH_GT) ?
							mkts_pkg::MODE_TEXT : mkts_pkg::MODE_TAG;
						n_pos  = 3'd0;
					end
					if (n_mode != mkts_pkg::MODE_OPEN) begin
						n_cand = 3'd0;
					end
				end
			end
			mkts_pkg::MODE_TAG, mkts_pkg::MODE_CLOSE: begin
				if (char_s1 == mkts_pkg::CH_GT) begin
					n_mode = mkts_pkg::MODE_TEXT;
				end
			end
			mkts_pkg::MODE_CMT: begin
				if (char_s1 == mkts_pkg::CH_GT && dash_q == 2'd2) begin
					n_mode = mkts_pkg::MODE_TEXT;
					n_dash = 2'd0;
				end else if (char_s1 == mkts_pkg::CH_DASH) begin
					if (dash_q != 2'd2) begin
						n_dash = dash_q + 2'd1;
					end
				end else begin
					n_dash = 2'd0;
				end
			end
			mkts_pkg::MODE_STYLE: begin
				if (pos_q < 3'(mkts_pkg::END_STYLE_LEN) &&
				    lc == mkts_pkg::end_style_char(pos_q)) begin
					if (p_inc == 4'(mkts_pkg::END_STYLE_LEN)) begin
						n_pos  = 3'd0;
						n_mode = mkts_pkg::MODE_CLOSE;
					end else begin
						n_pos = p_inc[2:0];
					end
				end else begin
					n_pos = (char_s1 == mkts_pkg::CH_LT) ? 3'd1 : 3'd0;
				end
			end
			mkts_pkg::MODE_SCRIPT: begin
				if (lc == mkts_pkg::end_script_char(pos_q)) begin
					if (p_inc == 4'(mkts_pkg::END_SCRIPT_LEN)) begin
						n_pos  = 3'd0;
						n_mode = mkts_pkg::MODE_CLOSE;
					end else begin
						n_pos = p_inc[2:0];
					end
				end else begin
					n_pos = (char_s1 == mkts_pkg::CH_LT) ? 3'd1 : 3'd0;
				end
			end
			default: begin
				if (char_s1 == mkts_pkg::CH_LT) begin
					n_mode = mkts_pkg::MODE_OPEN;
					n_pos  = 3'd0;
					n_cand = 3'b111;
				end else if (mkts_pkg::is_space(char_s1)) begin
					n_prev = 1'b1;
				end else begin
					n_prev = 1'b0;
				end
			end
		endcase
	end

	// Output logic: only plain text produces bytes.
	always_comb begin
		o_char  = 8'd0;
		o_valid = 1'b0;
		case (mode_q)
			mkts_pkg::MODE_OPEN, mkts_pkg::MODE_TAG, mkts_pkg::MODE_CLOSE,
			mkts_pkg::MODE_CMT, mkts_pkg::MODE_STYLE, mkts_pkg::MODE_SCRIPT: begin
			end
			default: begin
				if (char_s1 == mkts_pkg::CH_LT) begin
					o_valid = 1'b0;
				end else if (mkts_pkg::is_space(char_s1)) begin
					if (!prev_space_q) begin
						o_valid = 1'b1;
						o_char  = mkts_pkg::CH_SPACE;
					end
				end else begin
					o_valid = 1'b1;
					o_char  = char_s1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	// The last byte of a window returns the scanner to its reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= mkts_pkg::MODE_TEXT;
			pos_q        <= 3'd0;
			cand_q       <= 3'd0;
			dash_q       <= 2'd0;
			prev_space_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				mode_q       <= mkts_pkg::MODE_TEXT;
				pos_q        <= 3'd0;
				cand_q       <= 3'd0;
				dash_q       <= 2'd0;
				prev_space_q <= 1'b0;
			end else begin
				mode_q       <= n_mode;
				pos_q        <= n_pos;
				cand_q       <= n_cand;
				dash_q       <= n_dash;
				prev_space_q <= n_prev;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rslt_valid_q <= 1'b0;
		end else if (out_free) begin
			rslt_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_char_q  <= o_char;
			out_valid_q <= o_valid;
			out_last_q  <= last_s1;
		end
	end

	assign rslt_valid = rslt_valid_q;
	assign out_char   = out_char_q;
	assign out_valid  = out_valid_q;
	assign out_last   = out_last_q;

	`CHK_ASSERT(a_no_byte_is_zero, clk, arst_n,
		(rslt_valid && !out_valid) |-> (out_char == 8'd0))
	`CHK_ASSERT(a_last_resets_scan, clk, arst_n,
		(adv_s1 && last_s1) |=>
		(mode_q == mkts_pkg::MODE_TEXT && !prev_space_q && pos_q == 3'd0))
	`CHK_ASSERT(a_stall_cause, clk, arst_n,
		!in_ready |-> (valid_s1 && rslt_valid && !rslt_ready))
	`CHK_NEVER(a_cand_outside_open, clk, arst_n,
		(cand_q != 3'd0) && (mode_q != mkts_pkg::MODE_OPEN))
	`CHK_NEVER(a_dash_outside_cmt, clk, arst_n,
		(dash_q != 2'd0) && (mode_q != mkts_pkg::MODE_CMT))

endmodule
